>>> design/tstc_pkg.sv
`timescale 1ns / 1ps

package tstc_pkg;

	localparam int MAX_TAG_LEN = 4;
	localparam int TAG_CAP     = (MAX_TAG_LEN < 4) ? MAX_TAG_LEN : 4;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;

	localparam logic [31:0] START_TAG_RESET = 32'd16188;
	localparam logic [2:0]  START_LEN_RESET = 3'd2;
	localparam logic [31:0] END_TAG_RESET   = 32'd15935;
	localparam logic [2:0]  END_LEN_RESET   = 3'd2;

	typedef enum logic [1:0] {
		REG_START_BYTES = 2'd0,
		REG_START_LEN   = 2'd1,
		REG_END_BYTES   = 2'd2,
		REG_END_LEN     = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		BODY_NONE,
		BODY_CHAR,
		BODY_ESC_CHAR,
		BODY_OPEN,
		BODY_ECHO,
		BODY_PRINT
	} body_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       last_of_item;
		logic       stream_end;
		logic       ended_inside;
	} out_word_t;

	// everything the emitter needs to replay the results of one input word
	typedef struct packed {
		logic [1:0]  fc;
		logic [23:0] flush_bytes;
		body_t       body;
		logic [7:0]  c;
		logic        eos;
		logic        end_in_code;
		logic [4:0]  total;
	} plan_t;

	function automatic logic [2:0] eff_len(input logic [2:0] len);
		logic [2:0] cap;
		cap = 3'(TAG_CAP);
		if (len == 3'd0)
			return 3'd1;
		else if (len > cap)
			return cap;
		else
			return len;
	endfunction

	function automatic logic [4:0] body_len(input body_t b);
		case (b)
			BODY_NONE:     return 5'd0;
			BODY_CHAR:     return 5'd1;
			BODY_ESC_CHAR: return 5'd2;
			BODY_OPEN:     return 5'd2;
			BODY_ECHO:     return 5'd17;
			BODY_PRINT:    return 5'd18;
			default:       return 5'd0;
		endcase
	endfunction

	// "\nputs -nonewline \""
	function automatic logic [7:0] prefix_byte(input logic [4:0] idx);
		case (idx)
			5'd0:    return CH_NL;
			5'd1:    return 8'h70;
			5'd2:    return 8'h75;
			5'd3:    return 8'h74;
			5'd4:    return 8'h73;
			5'd5:    return 8'h20;
			5'd6:    return 8'h2D;
			5'd7:    return 8'h6E;
			5'd8:    return 8'h6F;
			5'd9:    return 8'h6E;
			5'd10:   return 8'h65;
			5'd11:   return 8'h77;
			5'd12:   return 8'h6C;
			5'd13:   return 8'h69;
			5'd14:   return 8'h6E;
			5'd15:   return 8'h65;
			5'd16:   return 8'h20;
			5'd17:   return CH_QUOTE;
			default: return 8'h00;
		endcase
	endfunction

endpackage

>>> design/tstc_front.sv
`timescale 1ns / 1ps

module tstc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  tstc_pkg::in_word_t in_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output tstc_pkg::plan_t   plan
);

	logic [31:0] start_bytes_q, end_bytes_q;
	logic [2:0]  start_len_q, end_len_q;
	logic        in_code_q, echo_q;
	logic [2:0]  match_q;

	logic        in_code_n, echo_n;
	logic [2:0]  match_n;
	logic [31:0] tag_bytes;
	logic [2:0]  tag_len, cnt0, cnt_inc;
	logic [7:0]  c, ch;
	logic        hit;

	always_comb begin
		c         = in_data.in_byte;
		tag_bytes = in_code_q ? end_bytes_q : start_bytes_q;
		tag_len   = in_code_q ? tstc_pkg::eff_len(end_len_q) : tstc_pkg::eff_len(start_len_q);
		cnt0      = (match_q >= tag_len) ? 3'd0 : match_q;
		ch        = tag_bytes[{cnt0[1:0], 3'b000} +: 8];
		hit       = (c == ch);
		cnt_inc   = cnt0 + 3'd1;

		in_code_n = in_code_q;
		echo_n    = echo_q;
		match_n   = match_q;

		plan.fc          = 2'd0;
		plan.flush_bytes = tag_bytes[23:0];
		plan.body        = tstc_pkg::BODY_NONE;
		plan.c           = c;
		plan.eos         = in_data.end_of_stream;

		if (in_code_q && echo_q && c == tstc_pkg::CH_EQ) begin
			echo_n    = 1'b0;
			plan.body = tstc_pkg::BODY_ECHO;
		end else begin
			if (in_code_q)
				echo_n = 1'b0;
			if (hit) begin
				if (cnt_inc >= tag_len) begin
					match_n   = 3'd0;
					in_code_n = !in_code_q;
					if (in_code_q) begin
						plan.body = tstc_pkg::BODY_PRINT;
					end else begin
						plan.body = tstc_pkg::BODY_OPEN;
						echo_n    = 1'b1;
					end
				end else begin
					match_n = cnt_inc;
				end
			end else begin
				plan.fc = cnt0[1:0];
				match_n = 3'd0;
				if (!in_code_q && (c inside {tstc_pkg::CH_LBRACE, tstc_pkg::CH_RBRACE,
						tstc_pkg::CH_DOLLAR, tstc_pkg::CH_LBRACK, tstc_pkg::CH_RBRACK,
						tstc_pkg::CH_QUOTE, tstc_pkg::CH_BSL}))
					plan.body = tstc_pkg::BODY_ESC_CHAR;
				else
					plan.body = tstc_pkg::BODY_CHAR;
			end
		end

		plan.end_in_code = in_code_n;
		if (in_data.end_of_stream) begin
			in_code_n = 1'b0;
			echo_n    = 1'b0;
			match_n   = 3'd0;
		end

		plan.total = {3'b000, plan.fc} + tstc_pkg::body_len(plan.body)
			+ {4'b0000, in_data.end_of_stream};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_bytes_q <= tstc_pkg::START_TAG_RESET;
			start_len_q   <= tstc_pkg::START_LEN_RESET;
			end_bytes_q   <= tstc_pkg::END_TAG_RESET;
			end_len_q     <= tstc_pkg::END_LEN_RESET;
			in_code_q     <= 1'b0;
			echo_q        <= 1'b0;
			match_q       <= 3'd0;
		end else begin
			if (accept) begin
				in_code_q <= in_code_n;
				echo_q    <= echo_n;
			end
			// a register write restarts tag matching
			if (cfg_we || accept)
				match_q <= cfg_we ? 3'd0 : match_n;
			if (cfg_we) begin
				case (cfg_index)
					tstc_pkg::REG_START_BYTES: start_bytes_q <= cfg_data;
					tstc_pkg::REG_START_LEN:   start_len_q   <= cfg_data[2:0];
					tstc_pkg::REG_END_BYTES:   end_bytes_q   <= cfg_data;
					tstc_pkg::REG_END_LEN:     end_len_q     <= cfg_data[2:0];
					default: ;
				endcase
			end
		end
	end

endmodule

>>> design/tstc_emit.sv
`timescale 1ns / 1ps

module tstc_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  tstc_pkg::plan_t     plan,
	output logic                free,
	output logic                out_valid,
	input  logic                out_ready,
	output tstc_pkg::out_word_t out_data
);

	tstc_pkg::plan_t     plan_s1;
	logic                busy_s1;
	logic [4:0]          idx_q;
	tstc_pkg::out_word_t out_q;
	logic                out_valid_q;

	logic                advance, is_last;
	logic [4:0]          j;
	logic [7:0]          body_byte;
	tstc_pkg::out_word_t res;

	always_comb begin
		j       = idx_q - {3'b000, plan_s1.fc};
		is_last = (idx_q == plan_s1.total - 5'd1);
		advance = busy_s1 && (!out_valid_q || out_ready);
		free    = !busy_s1 || (advance && is_last);

		case (plan_s1.body)
			tstc_pkg::BODY_CHAR:     body_byte = plan_s1.c;
			tstc_pkg::BODY_ESC_CHAR: body_byte = (j == 5'd0) ? tstc_pkg::CH_BSL : plan_s1.c;
			tstc_pkg::BODY_OPEN:     body_byte = (j == 5'd0) ? tstc_pkg::CH_QUOTE : tstc_pkg::CH_NL;
			tstc_pkg::BODY_ECHO:     body_byte = tstc_pkg::prefix_byte(j);
			tstc_pkg::BODY_PRINT:    body_byte = tstc_pkg::prefix_byte(j);
			default:                 body_byte = 8'h00;
		endcase

		res.last_of_item = is_last;
		res.stream_end   = 1'b0;
		res.ended_inside = 1'b0;
		res.has_byte     = 1'b1;
		if (idx_q < {3'b000, plan_s1.fc}) begin
			res.out_byte = plan_s1.flush_bytes[{idx_q[1:0], 3'b000} +: 8];
		end else if (j < tstc_pkg::body_len(plan_s1.body)) begin
			res.out_byte = body_byte;
		end else begin
			// status word closing the stream
			res.out_byte     = 8'h00;
			res.has_byte     = 1'b0;
			res.stream_end   = 1'b1;
			res.ended_inside = plan_s1.end_in_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			idx_q       <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? 5'd0 : idx_q + 5'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load && plan.total != 5'd0)
				busy_s1 <= 1'b1;
			else if (advance && is_last)
				busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= res;
		if (load)
			plan_s1 <= plan;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> design/template_tag_script_converter.sv
`timescale 1ns / 1ps
// A taken input word is registered into the emitter's plan register, and each of its result
// words is then registered into the output register. Throughput: one result word per cycle
// while out_ready holds; an input word yields at most 19 result words, and the next input
// word is taken as the last of them is sent, so plain bytes flow at one per cycle. Reset
// clears mode, partial tag match and echo flag, and loads the default tags '<?' and '?>'.
module template_tag_script_converter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tstc_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tstc_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	tstc_pkg::plan_t plan;
	logic            free, accept;

	assign in_ready  = free;
	assign accept    = in_valid && free;
	assign cfg_ready = 1'b1;

	tstc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_data   (in_data),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.plan      (plan)
	);

	tstc_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.plan      (plan),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 40;
	// newline, print keyword, space, quote; the echo prefix is the first 17 bytes
	localparam logic [8*18-1:0] PRINT_LEAD = "\nputs -nonewline \"";

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	tstc_pkg::in_word_t  in_data;
	logic                out_valid;
	logic                out_ready;
	tstc_pkg::out_word_t out_data;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [1:0]          cfg_index;
	logic [31:0]         cfg_data;

	template_tag_script_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// predictor copy of registers and state
	logic [31:0] start_bytes;
	logic [2:0]  start_len;
	logic [31:0] end_bytes;
	logic [2:0]  end_len;
	bit          in_code;
	int          match_cnt;
	bit          echo_pending;
	bit          tag_hit;
	bit          tag_done;
	logic [7:0]  emit_bytes[$];

	tstc_pkg::out_word_t script_q[$];
	int          words_sent;
	int          errors;
	bit          quiet_in;
	bit          quiet_out;

	function automatic int tag_span(input logic [2:0] len);
		int cap;
		cap = (tstc_pkg::MAX_TAG_LEN < 4) ? tstc_pkg::MAX_TAG_LEN : 4;
		if (cap < 1)
			cap = 1;
		if (len == 3'd0)
			return 1;
		if (len > cap)
			return cap;
		return len;
	endfunction

	function automatic logic [7:0] tag_char(input logic [31:0] bytes, input int idx);
		return bytes[8 * (idx % 4) +: 8];
	endfunction

	function automatic logic [7:0] nonzero(input logic [7:0] b);
		return (b == 8'h00) ? 8'h01 : b;
	endfunction

	function automatic bit needs_escape(input logic [7:0] c);
		return c == tstc_pkg::CH_LBRACE || c == tstc_pkg::CH_RBRACE ||
			c == tstc_pkg::CH_DOLLAR || c == tstc_pkg::CH_LBRACK ||
			c == tstc_pkg::CH_RBRACK || c == tstc_pkg::CH_QUOTE ||
			c == tstc_pkg::CH_BSL;
	endfunction

	// greedy match: a mismatch flushes the partial tag and leaves the byte to the caller
	function automatic void match_tag(input logic [7:0] c, input logic [31:0] bytes,
			input int span);
		tag_done = 0;
		if (match_cnt >= span)
			match_cnt = 0;
		if (c == tag_char(bytes, match_cnt)) begin
			tag_hit = 1;
			match_cnt++;
			if (match_cnt >= span) begin
				match_cnt = 0;
				tag_done = 1;
			end
		end else begin
			tag_hit = 0;
			for (int i = 0; i < match_cnt; i++)
				emit_bytes.push_back(tag_char(bytes, i));
			match_cnt = 0;
		end
	endfunction

	function automatic void predict_script(input logic [7:0] c, input logic eos);
		tstc_pkg::out_word_t w;
		emit_bytes.delete();
		if (!in_code) begin
			match_tag(c, start_bytes, tag_span(start_len));
			if (tag_hit) begin
				if (tag_done) begin
					emit_bytes.push_back(tstc_pkg::CH_QUOTE);
					emit_bytes.push_back(tstc_pkg::CH_NL);
					in_code = 1;
					echo_pending = 1;
				end
			end else begin
				if (needs_escape(c))
					emit_bytes.push_back(tstc_pkg::CH_BSL);
				emit_bytes.push_back(c);
			end
		end else if (echo_pending && c == tstc_pkg::CH_EQ) begin
			echo_pending = 0;
			for (int i = 0; i < 17; i++)
				emit_bytes.push_back(PRINT_LEAD[8 * (17 - i) +: 8]);
		end else begin
			echo_pending = 0;
			match_tag(c, end_bytes, tag_span(end_len));
			if (tag_hit) begin
				if (tag_done) begin
					for (int i = 0; i < 18; i++)
						emit_bytes.push_back(PRINT_LEAD[8 * (17 - i) +: 8]);
					in_code = 0;
				end
			end else begin
				emit_bytes.push_back(c);
			end
		end
		foreach (emit_bytes[i]) begin
			w.out_byte     = emit_bytes[i];
			w.has_byte     = 1'b1;
			w.last_of_item = (i == emit_bytes.size() - 1) && !eos;
			w.stream_end   = 1'b0;
			w.ended_inside = 1'b0;
			script_q.push_back(w);
		end
		if (eos) begin
			w.out_byte     = 8'h00;
			w.has_byte     = 1'b0;
			w.last_of_item = 1'b1;
			w.stream_end   = 1'b1;
			w.ended_inside = in_code;
			script_q.push_back(w);
			in_code      = 0;
			match_cnt    = 0;
			echo_pending = 0;
		end
	endfunction

	task automatic send_word(input logic [7:0] b, input logic eos);
		int gap;
		tstc_pkg::in_word_t w;
		if ($urandom_range(0, 24) == 0)
			quiet_in = !quiet_in;
		gap = quiet_in ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		w.in_byte       = b;
		w.end_of_stream = eos;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		predict_script(b, eos);
		words_sent++;
	endtask

	task automatic wait_drained();
		if (in_valid) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		while (script_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input tstc_pkg::reg_idx_t idx, input logic [31:0] val);
		wait_drained();
		// a word that only extends a tag match leaves nothing to wait on
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			tstc_pkg::REG_START_BYTES: start_bytes = val;
			tstc_pkg::REG_START_LEN:   start_len   = val[2:0];
			tstc_pkg::REG_END_BYTES:   end_bytes   = val;
			tstc_pkg::REG_END_LEN:     end_len     = val[2:0];
			default: ;
		endcase
		match_cnt = 0;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_tags(input logic [31:0] sb, input logic [31:0] sl,
			input logic [31:0] eb, input logic [31:0] el);
		cfg_write(tstc_pkg::REG_START_BYTES, sb);
		cfg_write(tstc_pkg::REG_START_LEN, sl);
		cfg_write(tstc_pkg::REG_END_BYTES, eb);
		cfg_write(tstc_pkg::REG_END_LEN, el);
	endtask

	function automatic logic [31:0] rand_tag();
		logic [31:0] t;
		for (int i = 0; i < 4; i++)
			t[8 * i +: 8] = $urandom_range(1, 255);
		return t;
	endfunction

	function automatic logic [7:0] pick_byte();
		logic [31:0] tag;
		int span;
		logic [7:0] b;
		tag  = in_code ? end_bytes : start_bytes;
		span = tag_span(in_code ? end_len : start_len);
		case ($urandom_range(0, 3))
			0: b = tag_char(tag, $urandom_range(0, span - 1));
			1: begin
				case ($urandom_range(0, 7))
					0: b = tstc_pkg::CH_LBRACE;
					1: b = tstc_pkg::CH_RBRACE;
					2: b = tstc_pkg::CH_DOLLAR;
					3: b = tstc_pkg::CH_LBRACK;
					4: b = tstc_pkg::CH_RBRACK;
					5: b = tstc_pkg::CH_QUOTE;
					6: b = tstc_pkg::CH_BSL;
					default: b = tstc_pkg::CH_EQ;
				endcase
			end
			default: b = $urandom_range(1, 255);
		endcase
		return nonzero(b);
	endfunction

	// one template: text, tags (whole or broken off), echo marks, last word ends the stream
	task automatic send_template(input int len);
		int k, n, span;
		logic [31:0] tag;
		logic [7:0] b;
		k = 0;
		while (k < len) begin
			tag  = in_code ? end_bytes : start_bytes;
			span = tag_span(in_code ? end_len : start_len);
			case ($urandom_range(0, 9))
				0, 1:    n = span;
				2:       n = $urandom_range(1, span);
				default: n = 0;
			endcase
			if (k + n >= len)
				n = 0;
			if (n > 0) begin
				for (int i = 0; i < n; i++)
					send_word(nonzero(tag_char(tag, i)), 1'b0);
				k += n;
			end else begin
				b = (echo_pending && $urandom_range(0, 1)) ? tstc_pkg::CH_EQ : pick_byte();
				send_word(b, k == len - 1);
				k++;
			end
		end
	endtask

	task automatic test_random_phase(input int budget);
		int target;
		target = words_sent + budget;
		while (words_sent < target)
			send_template($urandom_range(3, 30));
	endtask

	task automatic test_escapes();
		send_word(tstc_pkg::CH_LBRACE, 1'b0);
		send_word(tstc_pkg::CH_RBRACE, 1'b0);
		send_word(tstc_pkg::CH_DOLLAR, 1'b0);
		send_word(tstc_pkg::CH_LBRACK, 1'b0);
		send_word(tstc_pkg::CH_RBRACK, 1'b0);
		send_word(tstc_pkg::CH_QUOTE, 1'b0);
		send_word(tstc_pkg::CH_BSL, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h01, 1'b1);
	endtask

	task automatic test_tag_matching();
		// broken start tag, then a repeated first char that is not tested again
		send_word("<", 1'b0);
		send_word("x", 1'b0);
		send_word("<", 1'b0);
		send_word("<", 1'b0);
		send_word("?", 1'b0);
		// open, echo, broken end tag, close
		send_word("<", 1'b0);
		send_word("?", 1'b0);
		send_word(tstc_pkg::CH_EQ, 1'b0);
		send_word("?", 1'b0);
		send_word("x", 1'b0);
		send_word("?", 1'b0);
		send_word(">", 1'b0);
		// stream ends inside code with a partial end tag pending
		send_word("<", 1'b0);
		send_word("?", 1'b0);
		send_word("?", 1'b1);
	endtask

	task automatic test_write_clears_match();
		send_word("<", 1'b0);
		cfg_write(tstc_pkg::REG_START_LEN, 32'd2);
		send_word("?", 1'b0);
		send_word(">", 1'b1);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// result side: random stalls, each word checked against the oldest expectation
	initial begin
		int stall;
		tstc_pkg::out_word_t want;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 24) == 0)
				quiet_out = !quiet_out;
			stall = quiet_out ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (script_q.size() == 0) begin
				$error("result word %0h with nothing expected", out_data);
				errors++;
			end else begin
				want = script_q.pop_front();
				check_field("out_byte", want.out_byte, out_data.out_byte);
				check_field("has_byte", want.has_byte, out_data.has_byte);
				check_field("last_of_item", want.last_of_item, out_data.last_of_item);
				check_field("stream_end", want.stream_end, out_data.stream_end);
				check_field("ended_inside", want.ended_inside, out_data.ended_inside);
			end
		end
	end

	initial begin
		logic [31:0] r;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		out_ready    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = tstc_pkg::REG_START_BYTES;
		cfg_data     = '0;
		start_bytes  = 32'h0000_3F3C;
		start_len    = 3'd2;
		end_bytes    = 32'h0000_3E3F;
		end_len      = 3'd2;
		in_code      = 0;
		match_cnt    = 0;
		echo_pending = 0;
		words_sent   = 0;
		errors       = 0;
		quiet_in     = 0;
		quiet_out    = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_escapes();
		test_tag_matching();
		test_write_clears_match();

		test_random_phase(15);
		wait_drained();
		test_random_phase(15);

		// single-char start tag that is also an escaped char, full-length end tag
		r = $urandom();
		r[7:0] = tstc_pkg::CH_LBRACE;
		set_tags(r, 32'd1, rand_tag(), 32'd4);
		test_random_phase(30);

		// length 0 acts as 1, length 7 acts as the cap
		r = $urandom();
		set_tags(rand_tag(), {r[31:3], 3'd0}, rand_tag(), {r[31:3], 3'd7});
		test_random_phase(25);

		// all-ones start tag of repeated chars, end tag with a repeated first char
		r = rand_tag();
		r[15:8] = r[7:0];
		set_tags(32'hFFFF_FFFF, 32'd4, r, 32'd3);
		test_random_phase(25);

		// zero end tag never matches, so code sections close only at stream end
		set_tags(rand_tag(), 32'hFFFF_FFFA, 32'h0000_0000, 32'd1);
		test_random_phase(15);

		set_tags(32'h0000_3F3C, 32'd2, 32'h0000_3E3F, 32'd2);
		test_random_phase(15);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (script_q.size() != 0) begin
			$error("%0d result words never arrived", script_q.size());
			errors++;
		end
		if (errors == 0)
			$display("template_tag_script_converter regression: pass");
		else
			$display("template_tag_script_converter regression: fail");
		$finish;
	end

	initial begin
		#1000000;
		$display("template_tag_script_converter regression: fail");
		$finish;
	end

endmodule

>>> filelist.f
design/tstc_pkg.sv
design/tstc_front.sv
design/tstc_emit.sv
design/template_tag_script_converter.sv
bench/tb_top.sv
